// ----- design/material_tint_colorizer_unit_defines.svh -----
// Assertion macros used by the material tint colorizer top level.
`ifndef MATERIAL_TINT_COLORIZER_UNIT_DEFINES_SVH
`define MATERIAL_TINT_COLORIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_NOW(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_NEXT(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

// ----- design/mtc_pkg.sv -----
// Types and constants shared by the material tint colorizer modules.
`timescale 1ns / 1ps

package mtc_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW = $clog2(PAL_ENTRIES);
    localparam int PAL_DW = 24;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;

    localparam logic [7:0] MAT_FIRST = 8'd192;
    localparam logic [11:0] CHAN_MAX = 12'h7FF;

    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    typedef enum logic [2:0] {
        REG_MATERIAL_COLORS = 3'd0,
        REG_ALPHA_VALUES    = 3'd1,
        REG_BASE_ALPHA      = 3'd2,
        REG_RUST_LEVELS     = 3'd3,
        REG_BURN_LEVELS     = 3'd4,
        REG_ALLOW_REGULAR   = 3'd5,
        REG_TRANSPARENT     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] base_color;
        logic [3:0]  brightness;
        logic        rust_hit;
        logic        burn_hit;
    } shade_req_t;

endpackage

// ----- design/mtc_palette_ram.sv -----
// Palette memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mtc_palette_ram (
    input  logic                     clk,
    input  logic                     we,
    input  logic [mtc_pkg::PAL_AW-1:0] waddr,
    input  logic [mtc_pkg::PAL_DW-1:0] wdata,
    input  logic                     re,
    input  logic [mtc_pkg::PAL_AW-1:0] raddr,
    output logic [mtc_pkg::PAL_DW-1:0] rdata
);
    import mtc_pkg::*;

    logic [PAL_DW-1:0] mem [PAL_ENTRIES];
    logic [PAL_DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mtc_shade.sv -----
// Material pixel shading: brightness scale, rust, burn, saturation and packing.
`timescale 1ns / 1ps

module mtc_shade (
    input  mtc_pkg::shade_req_t req,
    output logic [15:0]         shaded
);
    import mtc_pkg::*;

    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    logic [11:0] mx;
    logic [11:0] mx_q;
    logic [13:0] g3;
    logic [11:0] r_s;
    logic [11:0] g_s;
    logic [11:0] b_s;

    always_comb
    begin
        r8 = {req.base_color[15:11], 3'b000};
        g8 = {req.base_color[10:5], 2'b00};
        b8 = {req.base_color[4:0], 3'b000};
        r = 12'(r8) * 12'(req.brightness);
        g = 12'(g8) * 12'(req.brightness);
        b = 12'(b8) * 12'(req.brightness);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        g3 = 14'(g) * 14'd3;
        if (req.rust_hit)
        begin
            g = g3[13:2];
            b = b >> 1;
        end
        mx_q = mx >> 2;
        if (req.burn_hit)
        begin
            r = mx_q + (r >> 3);
            g = mx_q + (g >> 3);
            b = mx_q + (b >> 3);
        end
        r_s = (r > CHAN_MAX) ? CHAN_MAX : r;
        g_s = (g > CHAN_MAX) ? CHAN_MAX : g;
        b_s = (b > CHAN_MAX) ? CHAN_MAX : b;
        shaded = {r_s[10:6], g_s[10:5], b_s[10:6]};
    end

endmodule

// ----- design/material_tint_colorizer_unit.sv -----
// Top level of the material tint colorizer: config port, seeds, pipeline, output.
`timescale 1ns / 1ps

// The input channel takes one word per cycle unless in_stall is raised: a
// palette load (mode 1) or a pixel to colorize (mode 0). Each pixel word yields
// one output word with the RGB565 color, the alpha byte and the alpha write
// flag; load words yield none. The user must write registers through the APB
// port only while the block is idle; the block itself does not enforce this.
// An accepted word passes the shading stage register and then the output
// register. The rate is set by the per-channel generator update, two constant
// multiplies done in the accept cycle together with the palette read. The second
// stage shades material pixels or packs the palette entry read from the
// registered palette memory (or the transparent color if regular pixels are
// off) into the output register. When the receiver stalls, the output register
// holds its word, the second stage still takes one more word, and then the input
// stall is raised. Reset clears the handshake state, the generator seeds and the
// registers to their defaults; the palette contents are undefined until loaded.

module material_tint_colorizer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mtc_pkg::CFG_AW-1:0] paddr,
    input  logic [mtc_pkg::CFG_DW-1:0] pwdata,
    output logic [mtc_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [7:0]                 pixel_index,
    input  logic                       first_of_image,
    input  logic [23:0]                palette_rgb,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                color,
    output logic [7:0]                 alpha,
    output logic                       alpha_write
);
    import mtc_pkg::*;

    `include "material_tint_colorizer_unit_defines.svh"

    logic [63:0] material_colors_reg;
    logic [31:0] alpha_values_reg;
    logic [7:0]  base_alpha_reg;
    logic [31:0] rust_levels_reg;
    logic [31:0] burn_levels_reg;
    logic        allow_regular_reg;
    logic [15:0] transparent_reg;

    logic        cfg_write;
    cfg_reg_t    cfg_sel;

    logic [31:0] rust_seed_reg [4];
    logic [31:0] burn_seed_reg [4];
    logic [31:0] rust_seed_next [4];
    logic [31:0] burn_seed_next [4];
    logic [31:0] rust_base [4];
    logic [31:0] burn_base [4];
    logic [31:0] rust_new;
    logic [31:0] burn_new;

    logic        advance;
    logic        in_acc;
    logic        in_mat;
    logic [7:0]  in_off;
    logic [1:0]  in_ch;
    logic [15:0] in_c;
    logic        in_ctrans;
    logic [7:0]  in_rl;
    logic [7:0]  in_bl;
    logic        step_rust;
    logic        step_burn;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_mat_reg;
    logic        s1_ctrans_reg;
    logic [1:0]  s1_ch_reg;
    logic [3:0]  s1_idx_reg;
    logic [15:0] s1_c_reg;
    logic        s1_rust_hit_reg;
    logic        s1_burn_hit_reg;

    logic                 pal_we;
    logic [PAL_DW-1:0]    pal_rdata;
    shade_req_t           shade_req;
    logic [15:0]          shaded;
    logic [15:0]          s1_color;
    logic [7:0]           s1_alpha;
    logic                 s1_awrite;
    logic                 alpha_in_use;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] color_reg;
    logic [7:0]  alpha_reg;
    logic        alpha_write_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            material_colors_reg <= '0;
            alpha_values_reg    <= 32'hFFFF_FFFF;
            base_alpha_reg      <= 8'hFF;
            rust_levels_reg     <= '0;
            burn_levels_reg     <= '0;
            allow_regular_reg   <= 1'b1;
            transparent_reg     <= 16'hF81F;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_MATERIAL_COLORS: material_colors_reg <= pwdata;
                REG_ALPHA_VALUES:    alpha_values_reg <= pwdata[31:0];
                REG_BASE_ALPHA:      base_alpha_reg <= pwdata[7:0];
                REG_RUST_LEVELS:     rust_levels_reg <= pwdata[31:0];
                REG_BURN_LEVELS:     burn_levels_reg <= pwdata[31:0];
                REG_ALLOW_REGULAR:   allow_regular_reg <= pwdata[0];
                REG_TRANSPARENT:     transparent_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_MATERIAL_COLORS: prdata = material_colors_reg;
            REG_ALPHA_VALUES:    prdata = {32'd0, alpha_values_reg};
            REG_BASE_ALPHA:      prdata = {56'd0, base_alpha_reg};
            REG_RUST_LEVELS:     prdata = {32'd0, rust_levels_reg};
            REG_BURN_LEVELS:     prdata = {32'd0, burn_levels_reg};
            REG_ALLOW_REGULAR:   prdata = {63'd0, allow_regular_reg};
            REG_TRANSPARENT:     prdata = {48'd0, transparent_reg};
            default:             prdata = '0;
        endcase
    end

    // Handshake.
    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_acc = in_valid && !in_stall;

    // Accept stage: channel decode and generator update.
    assign in_mat = (pixel_index >= MAT_FIRST);
    assign in_off = 8'(pixel_index - MAT_FIRST);
    assign in_ch = in_off[5:4];
    assign in_c = material_colors_reg[{in_ch, 4'b0000} +: 16];
    assign in_ctrans = (in_c == transparent_reg);
    assign in_rl = rust_levels_reg[{in_ch, 3'b000} +: 8];
    assign in_bl = burn_levels_reg[{in_ch, 3'b000} +: 8];
    assign step_rust = in_acc && !mode && in_mat && !in_ctrans && (in_rl != 8'd0);
    assign step_burn = in_acc && !mode && in_mat && !in_ctrans && (in_bl != 8'd0);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (first_of_image)
            begin
                rust_base[k] = 32'(rust_levels_reg[8*k+2 +: 6]);
                burn_base[k] = 32'(burn_levels_reg[8*k+2 +: 6]);
            end
            else
            begin
                rust_base[k] = rust_seed_reg[k];
                burn_base[k] = burn_seed_reg[k];
            end
        end
    end

    assign rust_new = rust_base[in_ch] * LCG_MUL + LCG_INC;
    assign burn_new = burn_base[in_ch] * LCG_MUL + LCG_INC;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rust_seed_next[k] = rust_seed_reg[k];
            burn_seed_next[k] = burn_seed_reg[k];
            if (in_acc && !mode)
            begin
                rust_seed_next[k] = rust_base[k];
                burn_seed_next[k] = burn_base[k];
                if (step_rust && (in_ch == 2'(k)))
                begin
                    rust_seed_next[k] = rust_new;
                end
                if (step_burn && (in_ch == 2'(k)))
                begin
                    burn_seed_next[k] = burn_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                rust_seed_reg[k] <= '0;
                burn_seed_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                rust_seed_reg[k] <= rust_seed_next[k];
                burn_seed_reg[k] <= burn_seed_next[k];
            end
        end
    end

    // Palette memory.
    assign pal_we = in_acc && mode && ({1'b0, pixel_index} < 9'(PAL_ENTRIES));

    mtc_palette_ram u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pixel_index[PAL_AW-1:0]),
        .wdata (palette_rgb),
        .re    (in_acc && !mode),
        .raddr (pixel_index[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    // Shading stage.
    always_comb
    begin
        if (in_acc)
        begin
            s1_valid_next = !mode;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_mat_reg      <= in_mat;
            s1_ctrans_reg   <= in_ctrans;
            s1_ch_reg       <= in_ch;
            s1_idx_reg      <= pixel_index[3:0];
            s1_c_reg        <= in_c;
            s1_rust_hit_reg <= step_rust && (in_rl[1:0] > rust_new[31:30]);
            s1_burn_hit_reg <= step_burn && (in_bl[1:0] > burn_new[31:30]);
        end
    end

    assign shade_req.base_color = s1_c_reg;
    assign shade_req.brightness = s1_idx_reg;
    assign shade_req.rust_hit   = s1_rust_hit_reg;
    assign shade_req.burn_hit   = s1_burn_hit_reg;

    mtc_shade u_shade (
        .req    (shade_req),
        .shaded (shaded)
    );

    assign alpha_in_use = (base_alpha_reg != 8'hFF) || (alpha_values_reg != 32'hFFFF_FFFF);

    always_comb
    begin
        if (s1_mat_reg)
        begin
            s1_color = s1_ctrans_reg ? transparent_reg : shaded;
            s1_alpha = alpha_values_reg[{s1_ch_reg, 3'b000} +: 8];
            s1_awrite = !s1_ctrans_reg && alpha_in_use;
        end
        else
        begin
            if (allow_regular_reg)
            begin
                s1_color = {pal_rdata[23:19], pal_rdata[15:10], pal_rdata[7:3]};
            end
            else
            begin
                s1_color = transparent_reg;
            end
            s1_alpha = base_alpha_reg;
            s1_awrite = 1'b0;
        end
    end

    // Output register.
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            color_reg       <= s1_color;
            alpha_reg       <= s1_alpha;
            alpha_write_reg <= s1_awrite;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color       = color_reg;
    assign alpha       = alpha_reg;
    assign alpha_write = alpha_write_reg;

    `MTC_ASSERT_NEXT(a_pixel_enters_stage, clk, rst_n, in_acc && !mode, s1_valid_reg, "accepted pixel word missing from shading stage")
    `MTC_ASSERT_NEXT(a_load_makes_no_word, clk, rst_n, in_acc && mode, !s1_valid_reg, "palette load produced a pixel word")
    `MTC_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_c_reg) && $stable(s1_idx_reg), "shading stage lost its word while stalled")
    `MTC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg, "input stalled with room in the pipeline")

endmodule
